FILE: src/vtd_pkg.sv
// shared constants and types for the vertex transform and perspective divide
// no dependencies; used by vtd_div and vertex_transform_divide
package vtd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PAIR_W    = 2 * COORD_W;
    localparam int NUM_PAIRS = 8;
    localparam int INDEX_W   = 4;
    // exact row sum of three full products and one shifted coefficient
    localparam int SUM_W     = PAIR_W + 2;
    // row sum after dropping the fraction bits of the product
    localparam int ROW_W     = SUM_W - FRAC_BITS;
    // quotient bits kept: anything at or above 2^QUOT_W saturates
    localparam int QUOT_W    = COORD_W + 1;
    localparam int PRE_SHIFT = QUOT_W - FRAC_BITS;
    // w-zero path: clamp to +-2^40, then multiply by 10000
    localparam int CLAMP_EXP = 40;
    localparam int SCALE_W   = 15;
    localparam int WZ_SCALE  = 10000;
    localparam int SCALED_W  = CLAMP_EXP + 1 + SCALE_W;

    typedef logic [ROW_W-1:0]  mag_t;
    typedef logic [QUOT_W-1:0] quot_t;

endpackage

FILE: src/vtd_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on vtd_pkg; quotient is floor(num * 2^FRAC_BITS / den), low QUOT_W bits
module vtd_div (
    input  logic          aclk,
    input  logic          en,
    input  vtd_pkg::mag_t num,
    input  vtd_pkg::mag_t den,
    input  vtd_pkg::mag_t rem_init,
    output vtd_pkg::quot_t quot
);

    localparam int QW = vtd_pkg::QUOT_W;
    localparam int RW = vtd_pkg::ROW_W;
    localparam int FB = vtd_pkg::FRAC_BITS;

    logic [RW-1:0] rem_reg [QW-1];
    logic [RW-1:0] num_reg [QW-1];
    logic [RW-1:0] den_reg [QW-1];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int I = QW - 1 - k;
        logic [RW-1:0] rem_in;
        logic [RW-1:0] num_in;
        logic [RW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic          nbit;
        logic [RW:0]   shifted;
        logic [RW:0]   diff;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = rem_init;
            assign num_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // next dividend bit of num shifted up by the fraction width
        if (I >= FB) begin : g_nbit
            assign nbit = num_in[I-FB];
        end else begin : g_zbit
            assign nbit = 1'b0;
        end

        assign shifted = {rem_in, nbit};
        assign take    = shifted >= {1'b0, den_in};
        assign diff    = shifted - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k] <= {q_in[QW-2:0], take};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? diff[RW-1:0] : shifted[RW-1:0];
                    num_reg[k] <= num_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quot = q_reg[QW-1];

endmodule

FILE: src/vertex_transform_divide.sv
// Vertex transform with perspective divide: each word (x, y, z in signed Q16.16) is
// extended with w = 1, multiplied by the loaded 4x4 matrix and divided by the resulting
// w, one word accepted per clock while m_ready does not stall. It registers the twelve
// products, the row sums and sign and magnitude, then passes the bit-per-stage divider and
// one output register. A stall on m_ready holds the whole pipeline. Load the matrix
// through cfg_* (index 0..7, two coefficients each, high half first) only while idle.
// depends on vtd_pkg and vtd_div
module vertex_transform_divide (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vtd_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [vtd_pkg::PAIR_W-1:0]        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [vtd_pkg::COORD_W-1:0] s_x_in,
    input  logic signed [vtd_pkg::COORD_W-1:0] s_y_in,
    input  logic signed [vtd_pkg::COORD_W-1:0] s_z_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [vtd_pkg::COORD_W-1:0] m_x_out,
    output logic signed [vtd_pkg::COORD_W-1:0] m_y_out,
    output logic signed [vtd_pkg::COORD_W-1:0] m_z_out,
    output logic                              m_w_zero,
    output logic                              m_saturated
);

    localparam int CW = vtd_pkg::COORD_W;
    localparam int RW = vtd_pkg::ROW_W;
    localparam int SW = vtd_pkg::SUM_W;
    localparam int QW = vtd_pkg::QUOT_W;
    localparam int FB = vtd_pkg::FRAC_BITS;
    localparam int PS = vtd_pkg::PRE_SHIFT;
    localparam int XW = vtd_pkg::SCALED_W;
    localparam int CE = vtd_pkg::CLAMP_EXP;
    // clamp bounds of the w-zero path, +-2^CE
    localparam logic signed [RW-1:0] CL_HI = RW'(1) << CE;
    localparam logic signed [RW-1:0] CL_LO = -CL_HI;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0]            ovf;
        logic                  wz;
        logic signed [XW-1:0]  xsc;
        logic signed [XW-1:0]  ysc;
    } side_t;

    logic [vtd_pkg::PAIR_W-1:0] pair_reg [vtd_pkg::NUM_PAIRS];
    logic signed [CW-1:0]       coef [4][4];
    logic                       en;

    logic                       v1_reg, v2_reg, v3_reg;
    logic signed [2*CW-1:0]     prod_reg [4][3];
    logic signed [CW-1:0]       c3_reg   [4];
    logic signed [RW-1:0]       row_reg  [4];

    vtd_pkg::mag_t              a_reg [3];
    vtd_pkg::mag_t              b_reg;
    side_t                      side_next;
    side_t                      side3_reg;
    side_t                      sd_reg [QW];
    logic [QW-1:0]              dv_reg;
    vtd_pkg::quot_t             quot [3];

    logic signed [CW-1:0]       res [3];
    logic [2:0]                 res_sat;
    logic signed [CW-1:0]       xs_out, ys_out;
    logic                       xs_sat, ys_sat;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vtd_pkg::NUM_PAIRS; i++) begin
                pair_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_index < vtd_pkg::INDEX_W'(vtd_pkg::NUM_PAIRS)) begin
            pair_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = c[0] ? pair_reg[r*2 + c/2][CW-1:0]
                                  : pair_reg[r*2 + c/2][2*CW-1:CW];
            end
        end
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                prod_reg[r][0] <= coef[r][0] * s_x_in;
                prod_reg[r][1] <= coef[r][1] * s_y_in;
                prod_reg[r][2] <= coef[r][2] * s_z_in;
                c3_reg[r]      <= coef[r][3];
            end
        end
    end

    // stage 2: exact sums, floored to FRAC_BITS fraction bits
    always_ff @(posedge aclk) begin
        logic signed [SW-1:0] sum;
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                sum = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2])
                    + SW'(signed'({c3_reg[r], {FB{1'b0}}}));
                row_reg[r] <= sum[SW-1:FB];
            end
        end
    end

    // stage 3: magnitudes, overflow precheck, w-zero scaling
    always_comb begin
        logic signed [CE+1:0] cl;
        logic [RW-1:0]        bm;
        bm = row_reg[3][RW-1] ? RW'(-row_reg[3]) : row_reg[3];
        side_next.wz = (row_reg[3] == '0);
        for (int i = 0; i < 3; i++) begin
            side_next.neg[i] = row_reg[i][RW-1] ^ row_reg[3][RW-1];
        end
        side_next.ovf = '0;
        side_next.xsc = '0;
        side_next.ysc = '0;
        for (int i = 0; i < 3; i++) begin
            side_next.ovf[i] =
                ({{PS{1'b0}}, (row_reg[i][RW-1] ? RW'(-row_reg[i]) : row_reg[i])}
                 >= {bm, {PS{1'b0}}});
        end
        cl = (row_reg[0] > CL_HI) ? (CE+2)'(CL_HI) :
             (row_reg[0] < CL_LO) ? (CE+2)'(CL_LO) :
             row_reg[0][CE+1:0];
        side_next.xsc = XW'(cl) * XW'(signed'(vtd_pkg::SCALE_W'(vtd_pkg::WZ_SCALE)));
        cl = (row_reg[1] > CL_HI) ? (CE+2)'(CL_HI) :
             (row_reg[1] < CL_LO) ? (CE+2)'(CL_LO) :
             row_reg[1][CE+1:0];
        side_next.ysc = XW'(cl) * XW'(signed'(vtd_pkg::SCALE_W'(vtd_pkg::WZ_SCALE)));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= row_reg[i][RW-1] ? RW'(-row_reg[i]) : row_reg[i];
            end
            b_reg     <= row_reg[3][RW-1] ? RW'(-row_reg[3]) : row_reg[3];
            side3_reg <= side_next;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        vtd_div u_div (
            .aclk     (aclk),
            .en       (en),
            .num      (a_reg[i]),
            .den      (b_reg),
            .rem_init (a_reg[i] >> PS),
            .quot     (quot[i])
        );
    end

    // sideband follows the divider stages
    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side3_reg;
            for (int k = 1; k < QW; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            dv_reg  <= '0;
            m_valid <= 1'b0;
        end else if (en) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            dv_reg  <= {dv_reg[QW-2:0], v3_reg};
            m_valid <= dv_reg[QW-1];
        end
    end

    // sign, clip and select
    always_comb begin
        side_t sd;
        sd = sd_reg[QW-1];
        for (int i = 0; i < 3; i++) begin
            if (sd.neg[i]) begin
                res_sat[i] = sd.ovf[i] || quot[i][QW-1]
                             || (quot[i][QW-2] && |quot[i][QW-3:0]);
                res[i] = res_sat[i] ? {1'b1, {(CW-1){1'b0}}} : CW'(-quot[i]);
            end else begin
                res_sat[i] = sd.ovf[i] || quot[i][QW-1] || quot[i][QW-2];
                res[i] = res_sat[i] ? {1'b0, {(CW-1){1'b1}}} : quot[i][CW-1:0];
            end
        end
        xs_sat = (sd.xsc > XW'(signed'({1'b0, {(CW-1){1'b1}}})))
              || (sd.xsc < XW'(signed'({1'b1, {(CW-1){1'b0}}})));
        xs_out = (sd.xsc > XW'(signed'({1'b0, {(CW-1){1'b1}}}))) ? {1'b0, {(CW-1){1'b1}}} :
                 (sd.xsc < XW'(signed'({1'b1, {(CW-1){1'b0}}}))) ? {1'b1, {(CW-1){1'b0}}} :
                 sd.xsc[CW-1:0];
        ys_sat = (sd.ysc > XW'(signed'({1'b0, {(CW-1){1'b1}}})))
              || (sd.ysc < XW'(signed'({1'b1, {(CW-1){1'b0}}})));
        ys_out = (sd.ysc > XW'(signed'({1'b0, {(CW-1){1'b1}}}))) ? {1'b0, {(CW-1){1'b1}}} :
                 (sd.ysc < XW'(signed'({1'b1, {(CW-1){1'b0}}}))) ? {1'b1, {(CW-1){1'b0}}} :
                 sd.ysc[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sd_reg[QW-1].wz) begin
                m_x_out     <= xs_out;
                m_y_out     <= ys_out;
                m_z_out     <= '0;
                m_w_zero    <= 1'b1;
                m_saturated <= xs_sat || ys_sat;
            end else begin
                m_x_out     <= res[0];
                m_y_out     <= res[1];
                m_z_out     <= res[2];
                m_w_zero    <= 1'b0;
                m_saturated <= |res_sat;
            end
        end
    end

    a_wz_zero_z: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_w_zero) |-> (m_z_out == '0))
        else $error("z not cleared on w zero word");

    a_enter_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v3_reg) |=> dv_reg[0])
        else $error("prepared word did not enter divider");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && dv_reg[QW-1] && !sd_reg[QW-1].wz && (|sd_reg[QW-1].ovf)) |=> m_saturated)
        else $error("quotient overflow not flagged");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en) |=> $stable(dv_reg))
        else $error("divider valid moved during stall");

endmodule
